/* design/cfa_pkg.sv */
package cfa_pkg;

  localparam int ADDR_BITS  = 20;
  localparam int OWNER_BITS = 8;
  localparam int SIZE_BITS  = ADDR_BITS + 1;
  localparam int MAX_SEG    = 32;
  localparam int IDX_BITS   = $clog2(MAX_SEG);
  localparam int CNT_BITS   = IDX_BITS + 1;

  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_REPORT  = 2'd2;
  localparam logic [1:0] MODE_NONE    = 2'd3;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOFIT   = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_NOOWNER = 3'd3;
  localparam logic [2:0] ST_BADSIZE = 3'd4;

  typedef struct packed {
    logic [ADDR_BITS-1:0]  seg_start;
    logic [ADDR_BITS-1:0]  seg_end;
    logic [OWNER_BITS-1:0] owner;
    logic                  used;
  } entry_t;

  // one table entry arriving from the memory read port
  typedef struct packed {
    logic                valid;
    logic [IDX_BITS-1:0] idx;
    entry_t              entry;
  } scan_t;

  typedef struct packed {
    logic                 found;
    logic [IDX_BITS-1:0]  pick;
    logic [SIZE_BITS-1:0] best;
    logic [ADDR_BITS-1:0] pick_start;
    logic [ADDR_BITS-1:0] pick_end;
  } fit_t;

endpackage

/* design/cfa_fit_track.sv */
module cfa_fit_track
  import cfa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clear,
  input  scan_t                scan,
  input  logic [SIZE_BITS-1:0] request_size,
  input  logic [1:0]           fit_strategy,
  output fit_t                 fit
);

  logic [SIZE_BITS-1:0] len;
  logic                 fits;
  logic                 take;

  always_comb begin
    len  = {1'b0, scan.entry.seg_end} - {1'b0, scan.entry.seg_start} + SIZE_BITS'(1);
    fits = scan.valid && !scan.entry.used && (len >= request_size);
    // first fit (and the unused code) keeps the earliest candidate
    take = fits && (!fit.found ||
                    (fit_strategy == FIT_BEST  && len < fit.best) ||
                    (fit_strategy == FIT_WORST && len > fit.best));
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      fit.found <= 1'b0;
    end else if (take) begin
      fit.found <= 1'b1;
    end
    if (take) begin
      fit.pick       <= scan.idx;
      fit.best       <= len;
      fit.pick_start <= scan.entry.seg_start;
      fit.pick_end   <= scan.entry.seg_end;
    end
  end

endmodule

/* design/contiguous_fit_allocator_unit.sv */
// Contiguous-fit allocator: an address-ordered table of up to 32 segments
// held in a one-port-read, one-port-write synchronous memory.
// Command channel: start/busy; a request is taken when start is high, busy
// and cfg_write are low and mode is not MODE_NONE. mode selects allocate,
// release owner or report all segments. Results come out on status/seg_*
// with result_strobe high for one cycle; the receiver cannot stall, and last
// marks the final result of a request. Allocate: one scan pass over the N
// live segments, then either the decision alone (exact fit or failure) or a
// shift of the entries above the picked one plus two writes for the split.
// Release: one read-merge-write pass, one result.
// Report: N results, one per cycle.
// Throughput is bounded by the single memory read port, one entry a cycle.
// cfg_write loads memory_size (write it only while idle; the block does not
// enforce this) and rebuilds the table as one free segment.
// After rst the block is busy writing that initial segment, memory_size = 2^20.
module contiguous_fit_allocator_unit
  import cfa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [SIZE_BITS-1:0]  cfg_data,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            mode,
  input  logic [OWNER_BITS-1:0] owner_id,
  input  logic [SIZE_BITS-1:0]  request_size,
  input  logic [1:0]            fit_strategy,
  output logic                  result_strobe,
  output logic [2:0]            status,
  output logic [ADDR_BITS-1:0]  seg_start,
  output logic [ADDR_BITS-1:0]  seg_end,
  output logic [OWNER_BITS-1:0] seg_owner,
  output logic                  seg_used,
  output logic                  last
);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_SHIFT  = 4'd4;
  localparam logic [3:0] S_SPLIT  = 4'd5;
  localparam logic [3:0] S_SPLIT2 = 4'd6;
  localparam logic [3:0] S_REL    = 4'd7;
  localparam logic [3:0] S_RPT    = 4'd8;

  localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(MAX_SEG);

  entry_t table_mem [MAX_SEG];
  entry_t mem_rdata, mem_wdata;
  logic   mem_we, mem_re;
  logic [IDX_BITS-1:0] mem_waddr, mem_raddr;

  logic [3:0]            state, state_next;
  logic [ADDR_BITS-1:0]  mem_last;
  logic [CNT_BITS-1:0]   cnt, cnt_next;
  logic [CNT_BITS-1:0]   ridx, ridx_next;
  logic                  rvalid, rvalid_next;
  logic [IDX_BITS-1:0]   didx, didx_next;
  logic [IDX_BITS-1:0]   wptr, wptr_next;
  entry_t                held, held_next;
  logic                  released, released_next;
  logic [1:0]            cmd_mode;
  logic [OWNER_BITS-1:0] cmd_owner;
  logic [SIZE_BITS-1:0]  cmd_size;
  logic [1:0]            cmd_fit;

  logic                  out_strobe;
  logic [2:0]            out_status;
  entry_t                out_entry;
  logic                  out_last;

  logic                  accept;
  logic                  track_clear;
  scan_t                 scan;
  fit_t                  fit;
  entry_t                rel_entry;
  logic [ADDR_BITS-1:0]  split_point;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy && !cfg_write && (mode != MODE_NONE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= table_mem[mem_raddr];
    end
  end

  assign scan.valid  = rvalid && (state == S_SCAN);
  assign scan.idx    = didx;
  assign scan.entry  = mem_rdata;
  assign track_clear = accept;

  cfa_fit_track u_fit (
    .clk          (clk),
    .rst          (rst),
    .clear        (track_clear),
    .scan         (scan),
    .request_size (cmd_size),
    .fit_strategy (cmd_fit),
    .fit          (fit)
  );

  assign split_point = fit.pick_start + cmd_size[ADDR_BITS-1:0];

  always_comb begin
    rel_entry = mem_rdata;
    if (mem_rdata.used && mem_rdata.owner == cmd_owner) begin
      rel_entry.used  = 1'b0;
      rel_entry.owner = '0;
    end
  end

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    ridx_next     = ridx;
    rvalid_next   = 1'b0;
    didx_next     = ridx[IDX_BITS-1:0];
    wptr_next     = wptr;
    held_next     = held;
    released_next = released;
    mem_we        = 1'b0;
    mem_waddr     = wptr;
    mem_wdata     = held;
    mem_re        = 1'b0;
    mem_raddr     = ridx[IDX_BITS-1:0];
    out_strobe    = 1'b0;
    out_status    = ST_OK;
    out_entry     = '0;
    out_last      = 1'b1;

    unique case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = '{seg_start: '0, seg_end: mem_last, owner: '0, used: 1'b0};
        cnt_next  = CNT_BITS'(1);
        state_next = S_IDLE;
      end
      S_IDLE: begin
        ridx_next     = '0;
        wptr_next     = '0;
        released_next = 1'b0;
        if (cfg_write) begin
          state_next = S_INIT;
        end else if (accept) begin
          unique case (mode)
            MODE_ALLOC:   state_next = S_SCAN;
            MODE_RELEASE: state_next = S_REL;
            default:      state_next = S_RPT;
          endcase
        end
      end
      S_SCAN, S_REL, S_RPT: begin
        if (ridx < cnt) begin
          mem_re      = 1'b1;
          rvalid_next = 1'b1;
          ridx_next   = ridx + CNT_BITS'(1);
        end
        if (state == S_RPT && rvalid) begin
          out_strobe = 1'b1;
          out_entry  = mem_rdata;
          if (!mem_rdata.used) begin
            out_entry.owner = '0;
          end
          out_last = ({1'b0, didx} == cnt - CNT_BITS'(1));
        end
        if (state == S_REL && rvalid) begin
          if (mem_rdata.used && mem_rdata.owner == cmd_owner) begin
            released_next = 1'b1;
          end
          if (didx == '0) begin
            held_next = rel_entry;
          end else if (!held.used && !rel_entry.used) begin
            held_next.seg_end = rel_entry.seg_end;
          end else begin
            mem_we    = 1'b1;
            wptr_next = wptr + IDX_BITS'(1);
            held_next = rel_entry;
          end
        end
        if (ridx == cnt && !rvalid) begin
          if (state == S_SCAN) begin
            state_next = S_DECIDE;
          end else if (state == S_REL) begin
            // flush the last pending segment and close the release
            mem_we     = 1'b1;
            cnt_next   = {1'b0, wptr} + CNT_BITS'(1);
            out_strobe = 1'b1;
            out_status = released ? ST_OK : ST_NOOWNER;
            state_next = S_IDLE;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_DECIDE: begin
        ridx_next = cnt - CNT_BITS'(1);
        priority if (cmd_size == '0) begin
          out_strobe = 1'b1;
          out_status = ST_BADSIZE;
          state_next = S_IDLE;
        end else if (!fit.found) begin
          out_strobe = 1'b1;
          out_status = ST_NOFIT;
          state_next = S_IDLE;
        end else if (fit.best == cmd_size) begin
          mem_we     = 1'b1;
          mem_waddr  = fit.pick;
          mem_wdata  = '{seg_start: fit.pick_start, seg_end: fit.pick_end,
                         owner: cmd_owner, used: 1'b1};
          out_strobe = 1'b1;
          out_entry  = mem_wdata;
          state_next = S_IDLE;
        end else if (cnt == CNT_MAX) begin
          out_strobe = 1'b1;
          out_status = ST_FULL;
          state_next = S_IDLE;
        end else begin
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        // move entries above the pick up by one, reading ahead of the write
        if (ridx > {1'b0, fit.pick}) begin
          mem_re      = 1'b1;
          rvalid_next = 1'b1;
          ridx_next   = ridx - CNT_BITS'(1);
        end
        if (rvalid) begin
          mem_we    = 1'b1;
          mem_waddr = didx + IDX_BITS'(1);
          mem_wdata = mem_rdata;
        end
        if (!(ridx > {1'b0, fit.pick}) && !rvalid) begin
          state_next = S_SPLIT;
        end
      end
      S_SPLIT: begin
        mem_we     = 1'b1;
        mem_waddr  = fit.pick + IDX_BITS'(1);
        mem_wdata  = '{seg_start: split_point, seg_end: fit.pick_end,
                       owner: '0, used: 1'b0};
        cnt_next   = cnt + CNT_BITS'(1);
        state_next = S_SPLIT2;
      end
      S_SPLIT2: begin
        mem_we     = 1'b1;
        mem_waddr  = fit.pick;
        mem_wdata  = '{seg_start: fit.pick_start,
                       seg_end: split_point - ADDR_BITS'(1),
                       owner: cmd_owner, used: 1'b1};
        out_strobe = 1'b1;
        out_entry  = mem_wdata;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_INIT;
      mem_last      <= '1;
      cnt           <= CNT_BITS'(1);
      ridx          <= '0;
      rvalid        <= 1'b0;
      wptr          <= '0;
      released      <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      cnt           <= cnt_next;
      ridx          <= ridx_next;
      rvalid        <= rvalid_next;
      wptr          <= wptr_next;
      released      <= released_next;
      result_strobe <= out_strobe;
      if (cfg_write) begin
        // zero is taken as one byte, anything past the address space is clipped
        priority if (cfg_data == '0) begin
          mem_last <= '0;
        end else if (cfg_data[SIZE_BITS-1]) begin
          mem_last <= '1;
        end else begin
          mem_last <= cfg_data[ADDR_BITS-1:0] - ADDR_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    didx <= didx_next;
    held <= held_next;
    if (accept) begin
      cmd_mode  <= mode;
      cmd_owner <= owner_id;
      cmd_size  <= request_size;
      cmd_fit   <= fit_strategy;
    end
    status    <= out_status;
    seg_start <= out_entry.seg_start;
    seg_end   <= out_entry.seg_end;
    seg_owner <= out_entry.owner;
    seg_used  <= out_entry.used;
    last      <= out_last;
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt != '0 && cnt <= CNT_MAX)
    else $error("segment count out of range");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> mem_waddr != mem_raddr)
    else $error("table read and write hit the same entry");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted request did not start work");

  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |=> $stable(cnt))
    else $error("segment count changed while idle");

  a_release_mode: assert property (@(posedge clk) disable iff (rst)
    (state == S_REL) |-> cmd_mode == MODE_RELEASE)
    else $error("release pass without a release request");
`endif

endmodule

/* tb/tb_contiguous_fit_allocator_unit.sv */
module tb_contiguous_fit_allocator_unit;
  import cfa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE = 100;

  typedef struct {
    logic [2:0]            st;
    logic [ADDR_BITS-1:0]  s;
    logic [ADDR_BITS-1:0]  e;
    logic [OWNER_BITS-1:0] o;
    logic                  u;
    logic                  l;
  } seg_result_t;

  typedef struct {
    logic [1:0]            md;
    logic [OWNER_BITS-1:0] own;
    logic [SIZE_BITS-1:0]  sz;
    logic [1:0]            fit;
    bit                    typed;
    seg_result_t           want;
  } cmd_row_t;

  logic                  clk = 0;
  logic                  rst = 1;
  logic                  cfg_write = 0;
  logic [SIZE_BITS-1:0]  cfg_data = '0;
  logic                  start = 0;
  logic                  busy;
  logic [1:0]            mode = MODE_NONE;
  logic [OWNER_BITS-1:0] owner_id = '0;
  logic [SIZE_BITS-1:0]  request_size = '0;
  logic [1:0]            fit_strategy = FIT_FIRST;
  logic                  result_strobe;
  logic [2:0]            status;
  logic [ADDR_BITS-1:0]  seg_start;
  logic [ADDR_BITS-1:0]  seg_end;
  logic [OWNER_BITS-1:0] seg_owner;
  logic                  seg_used;
  logic                  last;

  contiguous_fit_allocator_unit dut (.*);

  always #5 clk = ~clk;

  // allocator mirror
  logic [SIZE_BITS-1:0]  mem_bytes;
  logic [ADDR_BITS-1:0]  tbl_s[MAX_SEG];
  logic [ADDR_BITS-1:0]  tbl_e[MAX_SEG];
  logic [OWNER_BITS-1:0] tbl_o[MAX_SEG];
  logic                  tbl_u[MAX_SEG];
  int                    tbl_n;

  seg_result_t pending[$];
  seg_result_t fresh[$];
  int errors = 0;
  int cycles = 0;

  function automatic seg_result_t mk(logic [2:0] st, logic [ADDR_BITS-1:0] s,
                                     logic [ADDR_BITS-1:0] e, logic [OWNER_BITS-1:0] o,
                                     logic u, logic l);
    seg_result_t r;
    r.st = st; r.s = s; r.e = e; r.o = o; r.u = u; r.l = l;
    return r;
  endfunction

  function automatic void table_reset(logic [SIZE_BITS-1:0] v);
    if (v == 0) v = 1;
    if (v > (1 << ADDR_BITS)) v = 1 << ADDR_BITS;
    mem_bytes = v;
    for (int i = 0; i < MAX_SEG; i++) begin
      tbl_s[i] = 0; tbl_e[i] = 0; tbl_o[i] = 0; tbl_u[i] = 0;
    end
    tbl_e[0] = ADDR_BITS'(v - 1);
    tbl_n = 1;
  endfunction

  function automatic void drop_entry(int k);
    for (int j = k; j + 1 < tbl_n; j++) begin
      tbl_s[j] = tbl_s[j+1]; tbl_e[j] = tbl_e[j+1];
      tbl_o[j] = tbl_o[j+1]; tbl_u[j] = tbl_u[j+1];
    end
    tbl_n--;
    tbl_s[tbl_n] = 0; tbl_e[tbl_n] = 0; tbl_o[tbl_n] = 0; tbl_u[tbl_n] = 0;
  endfunction

  // fills fresh with the results the command causes and updates the mirror
  function automatic void allocator_step(logic [1:0] md, logic [OWNER_BITS-1:0] own,
                                         logic [SIZE_BITS-1:0] sz, logic [1:0] fit);
    bit found;
    bit freed;
    int pick;
    int i;
    logic [SIZE_BITS-1:0] len;
    logic [SIZE_BITS-1:0] best;
    found = 0; freed = 0; pick = 0; best = 0;
    fresh.delete();
    case (md)
      MODE_ALLOC: begin
        if (sz == 0) begin
          fresh.push_back(mk(ST_BADSIZE, 0, 0, 0, 0, 1));
          return;
        end
        for (i = 0; i < tbl_n; i++) begin
          if (tbl_u[i]) continue;
          len = SIZE_BITS'(tbl_e[i]) - SIZE_BITS'(tbl_s[i]) + 1;
          if (len < sz) continue;
          if (!found) begin
            found = 1; pick = i; best = len;
            if (fit != FIT_BEST && fit != FIT_WORST) break;
          end else if ((fit == FIT_BEST && len < best) || (fit == FIT_WORST && len > best)) begin
            pick = i; best = len;
          end
        end
        if (!found) begin
          fresh.push_back(mk(ST_NOFIT, 0, 0, 0, 0, 1));
          return;
        end
        if (best != sz) begin
          if (tbl_n >= MAX_SEG) begin
            fresh.push_back(mk(ST_FULL, 0, 0, 0, 0, 1));
            return;
          end
          for (i = tbl_n; i > pick + 1; i--) begin
            tbl_s[i] = tbl_s[i-1]; tbl_e[i] = tbl_e[i-1];
            tbl_o[i] = tbl_o[i-1]; tbl_u[i] = tbl_u[i-1];
          end
          tbl_s[pick+1] = tbl_s[pick] + ADDR_BITS'(sz);
          tbl_e[pick+1] = tbl_e[pick];
          tbl_o[pick+1] = 0;
          tbl_u[pick+1] = 0;
          tbl_e[pick] = tbl_s[pick] + ADDR_BITS'(sz) - 1;
          tbl_n++;
        end
        tbl_u[pick] = 1;
        tbl_o[pick] = own;
        fresh.push_back(mk(ST_OK, tbl_s[pick], tbl_e[pick], own, 1, 1));
      end
      MODE_RELEASE: begin
        for (i = 0; i < tbl_n; i++)
          if (tbl_u[i] && tbl_o[i] == own) begin
            tbl_u[i] = 0; tbl_o[i] = 0; freed = 1;
          end
        i = 1;
        while (i < tbl_n) begin
          if (!tbl_u[i] && !tbl_u[i-1]) begin
            tbl_e[i-1] = tbl_e[i];
            drop_entry(i);
          end else begin
            i++;
          end
        end
        fresh.push_back(mk(freed ? ST_OK : ST_NOOWNER, 0, 0, 0, 0, 1));
      end
      MODE_REPORT: begin
        for (i = 0; i < tbl_n; i++)
          fresh.push_back(mk(ST_OK, tbl_s[i], tbl_e[i], tbl_u[i] ? tbl_o[i] : '0,
                             tbl_u[i], i + 1 == tbl_n));
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    seg_result_t w;
    if (!rst && result_strobe) begin
      if (pending.size() == 0) begin
        $error("unexpected result: status %0d start %0h", status, seg_start);
        errors++;
      end else begin
        w = pending.pop_front();
        if (status !== w.st) begin
          $error("status exp %0d got %0d", w.st, status); errors++;
        end
        if (seg_start !== w.s) begin
          $error("seg_start exp %0h got %0h", w.s, seg_start); errors++;
        end
        if (seg_end !== w.e) begin
          $error("seg_end exp %0h got %0h", w.e, seg_end); errors++;
        end
        if (seg_owner !== w.o) begin
          $error("seg_owner exp %0d got %0d", w.o, seg_owner); errors++;
        end
        if (seg_used !== w.u) begin
          $error("seg_used exp %0d got %0d", w.u, seg_used); errors++;
        end
        if (last !== w.l) begin
          $error("last exp %0d got %0d", w.l, last); errors++;
        end
      end
    end
  end

  // returns with start still high unless a gap was drawn
  task automatic issue(cmd_row_t c);
    int gap;
    start <= 1;
    mode <= c.md;
    owner_id <= c.own;
    request_size <= c.sz;
    fit_strategy <= c.fit;
    @(posedge clk);
    while (busy) @(posedge clk);
    allocator_step(c.md, c.own, c.sz, c.fit);
    if (c.typed) begin
      pending.push_back(c.want);
    end else begin
      foreach (fresh[k]) pending.push_back(fresh[k]);
    end
    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_memory(logic [SIZE_BITS-1:0] v);
    drain();
    while (busy) @(posedge clk);
    cfg_write <= 1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 0;
    table_reset(v);
  endtask

  function automatic cmd_row_t row(logic [1:0] md, logic [OWNER_BITS-1:0] own,
                                   logic [SIZE_BITS-1:0] sz, logic [1:0] fit);
    cmd_row_t c;
    c.md = md; c.own = own; c.sz = sz; c.fit = fit; c.typed = 0;
    c.want = mk(ST_OK, 0, 0, 0, 0, 1);
    return c;
  endfunction

  function automatic cmd_row_t row_w(logic [1:0] md, logic [OWNER_BITS-1:0] own,
                                     logic [SIZE_BITS-1:0] sz, logic [1:0] fit,
                                     seg_result_t w);
    cmd_row_t c;
    c = row(md, own, sz, fit);
    c.typed = 1;
    c.want = w;
    return c;
  endfunction

  function automatic cmd_row_t random_cmd();
    int pct;
    logic [SIZE_BITS-1:0] sz;
    logic [OWNER_BITS-1:0] own;
    pct = $urandom_range(0, 99);
    own = ($urandom_range(0, 3) == 0) ? OWNER_BITS'($urandom) : OWNER_BITS'($urandom_range(0, 7));
    case ($urandom_range(0, 9))
      0: sz = SIZE_BITS'($urandom);
      1: sz = 0;
      2: sz = mem_bytes;
      default: sz = SIZE_BITS'($urandom_range(1, (mem_bytes > 8) ? mem_bytes / 6 : mem_bytes));
    endcase
    if (pct < 55) return row(MODE_ALLOC, own, sz, 2'($urandom_range(0, 3)));
    if (pct < 80) return row(MODE_RELEASE, own, SIZE_BITS'($urandom), 2'($urandom));
    if (pct < 95) return row(MODE_REPORT, own, SIZE_BITS'($urandom), 2'($urandom));
    return row(MODE_NONE, own, SIZE_BITS'($urandom), 2'($urandom));
  endfunction

  cmd_row_t directed[$];
  logic [SIZE_BITS-1:0] sizes[$];

  initial begin
    table_reset(1 << ADDR_BITS);
    directed = '{
      row_w(MODE_REPORT, 0, 0, FIT_FIRST, mk(ST_OK, 0, 20'hFFFFF, 0, 0, 1)),
      row_w(MODE_ALLOC, 0, 0, FIT_FIRST, mk(ST_BADSIZE, 0, 0, 0, 0, 1)),
      row_w(MODE_ALLOC, 255, 21'h1FFFFF, FIT_WORST, mk(ST_NOFIT, 0, 0, 0, 0, 1)),
      row_w(MODE_RELEASE, 7, 0, FIT_FIRST, mk(ST_NOOWNER, 0, 0, 0, 0, 1)),
      row_w(MODE_ALLOC, 1, 21'h100000, FIT_FIRST, mk(ST_OK, 0, 20'hFFFFF, 1, 1, 1)),
      row(MODE_REPORT, 0, 0, FIT_FIRST),
      row_w(MODE_RELEASE, 1, 0, FIT_FIRST, mk(ST_OK, 0, 0, 0, 0, 1)),
      row_w(MODE_ALLOC, 2, 100, FIT_FIRST, mk(ST_OK, 0, 99, 2, 1, 1)),
      row(MODE_ALLOC, 3, 50, FIT_BEST),
      row(MODE_ALLOC, 4, 200, FIT_WORST),
      row(MODE_ALLOC, 8, 40, FIT_FIRST),
      row(MODE_RELEASE, 3, 0, FIT_FIRST),
      row(MODE_ALLOC, 5, 10, 2'd3),
      row(MODE_ALLOC, 6, 30, FIT_BEST),
      row(MODE_ALLOC, 9, 500, FIT_WORST),
      row(MODE_REPORT, 0, 0, FIT_FIRST),
      row(MODE_NONE, 8'hFF, 21'h1FFFFF, 2'd3),
      row(MODE_RELEASE, 2, 0, FIT_FIRST),
      row(MODE_RELEASE, 4, 0, FIT_FIRST),
      row(MODE_REPORT, 0, 0, FIT_FIRST)
    };
    repeat (10) @(posedge clk);
    rst <= 0;
    foreach (directed[i]) issue(directed[i]);

    // fill the table with one-byte blocks until a split is refused
    set_memory(40);
    for (int i = 0; i < 31; i++) issue(row(MODE_ALLOC, OWNER_BITS'(i), 1, FIT_FIRST));
    issue(row(MODE_ALLOC, 200, 1, FIT_BEST));
    issue(row(MODE_ALLOC, 201, 9, FIT_WORST));
    issue(row(MODE_REPORT, 0, 0, FIT_FIRST));
    issue(row(MODE_RELEASE, 5, 0, FIT_FIRST));
    issue(row(MODE_REPORT, 0, 0, FIT_FIRST));

    sizes = '{1, 21'h1FFFFF, 0, 64, 300, 4096, 21'h100000, 21'($urandom_range(2, 100000))};
    foreach (sizes[p]) begin
      set_memory(sizes[p]);
      for (int n = 0; n < 21; n++) issue(random_cmd());
    end

    drain();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sim.f */
design/cfa_pkg.sv
design/cfa_fit_track.sv
design/contiguous_fit_allocator_unit.sv
tb/tb_contiguous_fit_allocator_unit.sv
